// ===== hw/rtl/pps_interval_error_averager_core_assert.svh =====
// Assertion macros for the PPS interval error averager checker.
// Depends on nothing; included by the checker file only.
`ifndef PPS_INTERVAL_ERROR_AVERAGER_CORE_ASSERT_SVH
`define PPS_INTERVAL_ERROR_AVERAGER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PPSIEA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PPSIEA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches reset itself.
`define PPSIEA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ppsiea_pkg.sv =====
// Shared types and constants of the PPS interval error averager.
// No dependencies; imported by every module of the block.
package ppsiea_pkg;

   localparam int TIME_W = 32;
   localparam int CNT_W  = 8;
   localparam int SUM_W  = 40;
   localparam int MEAN_W = 40;
   localparam int CSR_W  = 32;

   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam logic [TIME_W-1:0] NOMINAL_RESET = 32'd1000000;
   localparam logic [CNT_W-1:0]  WINDOW_RESET  = 8'd60;
   localparam logic [MEAN_W-1:0] MEAN_MAX      = 40'h7F_FFFF_FFFF;

   // register indexes of the configuration port
   localparam logic CSR_NOMINAL = 1'b0;
   localparam logic CSR_WINDOW  = 1'b1;

   // one classified sample handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] edge_number;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] error;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
   } rec_type;

   // handshake between queue and its two sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/pps_interval_error_averager_core.sv =====
// Top level of the PPS interval error averager: front, queue and back.
// Depends on ppsiea_pkg, ppsiea_front, ppsiea_queue, ppsiea_back.
//
//   channel  direction  handshake           payload
//   req      in         req_push / req_full  req_edge_time_us
//   rsp      out        rsp_pop / rsp_empty  rsp_edge_number, rsp_period,
//                                            rsp_period_error, rsp_mean_error_q8,
//                                            rsp_samples_averaged
//   csr      in         csr_we               csr_index, csr_wdata
//
// The front takes an edge only while idle and passes it through its error, sum
// and push states before it takes the next one; an edge that gives a result then
// goes through the back, where a one-bit-a-cycle restoring divider forms the mean.
// The back pops the next sample only once the last result is loaded.
// Reset is synchronous and active high and leaves no clearing pass. The two-entry
// queue and the result register let the front keep taking edges while a result
// waits for rsp_pop.
module pps_interval_error_averager_core #(
   parameter int FRACTION_BITS = ppsiea_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [ppsiea_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [ppsiea_pkg::TIME_W-1:0]          req_edge_time_us,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [ppsiea_pkg::TIME_W-1:0]          rsp_edge_number,
   output logic [ppsiea_pkg::TIME_W-1:0]          rsp_period,
   output logic signed [ppsiea_pkg::TIME_W-1:0]   rsp_period_error,
   output logic signed [ppsiea_pkg::MEAN_W-1:0]   rsp_mean_error_q8,
   output logic [ppsiea_pkg::CNT_W-1:0]           rsp_samples_averaged
);
   import ppsiea_pkg::*;

   // classified samples travel front -> queue -> back
   rec_type    front_rec;
   rec_type    back_rec;
   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;

   // front: timestamps, edge count, window sum and sample count
   ppsiea_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_edge_time_us (req_edge_time_us),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_rec            (front_rec)
   );

   // hold up to two samples so either side can stall alone
   ppsiea_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (front_rec),
      .pop   (q_pop),
      .dout  (back_rec),
      .stat  (q_stat)
   );

   // back: divide, clamp to 40 signed bits, present the result
   ppsiea_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_rec                (back_rec),
      .q_stat               (q_stat),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_edge_number      (rsp_edge_number),
      .rsp_period           (rsp_period),
      .rsp_period_error     (rsp_period_error),
      .rsp_mean_error_q8    (rsp_mean_error_q8),
      .rsp_samples_averaged (rsp_samples_averaged)
   );

endmodule

// ===== hw/rtl/ppsiea_front.sv =====
// Front part: takes edges, keeps edge time, count and error window state.
// Depends on ppsiea_pkg; feeds ppsiea_queue.
module ppsiea_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [ppsiea_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [ppsiea_pkg::TIME_W-1:0]     req_edge_time_us,
   input  ppsiea_pkg::q_stat_type            q_stat,
   output logic                              q_push,
   output ppsiea_pkg::rec_type               q_rec
);
   import ppsiea_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_ERR, F_SUM, F_PUSH} fstate_type;

   fstate_type        state_ff;
   logic [TIME_W-1:0] nominal_ff;
   logic [CNT_W-1:0]  window_ff;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] edges_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [TIME_W-1:0] interval_ff;
   logic [TIME_W-1:0] err_ff;
   logic              restart_ff;

   logic              accept;
   logic [CNT_W:0]    count_inc;
   logic              restart_in;
   logic [SUM_W-1:0]  err_ext;

   always_comb begin
      req_full   = (state_ff != F_IDLE);
      accept     = req_push && !req_full;
      count_inc  = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
      restart_in = (count_inc > {1'b0, window_ff});
      err_ext    = {{(SUM_W-TIME_W){err_ff[TIME_W-1]}}, err_ff};
      q_push     = (state_ff == F_PUSH) && !q_stat.full;
      q_rec.edge_number = edges_ff;
      q_rec.interval    = interval_ff;
      q_rec.error       = err_ff;
      q_rec.sum         = sum_ff;
      q_rec.count       = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         nominal_ff <= NOMINAL_RESET;
         window_ff  <= WINDOW_RESET;
         last_ff    <= '0;
         edges_ff   <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NOMINAL: nominal_ff <= csr_wdata[TIME_W-1:0];
               CSR_WINDOW:  window_ff  <= csr_wdata[CNT_W-1:0];
               default:     nominal_ff <= nominal_ff;
            endcase
         end
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  interval_ff <= req_edge_time_us - last_ff;
                  last_ff     <= req_edge_time_us;
                  edges_ff    <= edges_ff + {{(TIME_W-1){1'b0}}, 1'b1};
                  // drop the first edge and the edges where the count wraps to 0 or 1
                  if (edges_ff != '0 && edges_ff != '1) begin
                     state_ff <= F_ERR;
                  end
               end
            end
            F_ERR: begin
               err_ff     <= interval_ff - nominal_ff;
               restart_ff <= restart_in;
               count_ff   <= restart_in ? {{(CNT_W-1){1'b0}}, 1'b1} : count_inc[CNT_W-1:0];
               state_ff   <= F_SUM;
            end
            F_SUM: begin
               sum_ff   <= restart_ff ? err_ext : sum_ff + err_ext;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_stat.full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/ppsiea_queue.sv =====
// Two-entry queue of classified samples between front and back.
// Depends on ppsiea_pkg.
module ppsiea_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ppsiea_pkg::rec_type        din,
   input  logic                       pop,
   output ppsiea_pkg::rec_type        dout,
   output ppsiea_pkg::q_stat_type     stat
);
   import ppsiea_pkg::*;

   rec_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      stat.full  = (fill_ff == 2'd2);
      stat.empty = (fill_ff == 2'd0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      dout       = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/ppsiea_back.sv =====
// Back part: restoring divider for the fixed-point mean, clamp, result register.
// Depends on ppsiea_pkg; drains ppsiea_queue.
module ppsiea_back #(
   parameter int FRACTION_BITS = ppsiea_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ppsiea_pkg::rec_type                    q_rec,
   input  ppsiea_pkg::q_stat_type                 q_stat,
   output logic                                   q_pop,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [ppsiea_pkg::TIME_W-1:0]          rsp_edge_number,
   output logic [ppsiea_pkg::TIME_W-1:0]          rsp_period,
   output logic signed [ppsiea_pkg::TIME_W-1:0]   rsp_period_error,
   output logic signed [ppsiea_pkg::MEAN_W-1:0]   rsp_mean_error_q8,
   output logic [ppsiea_pkg::CNT_W-1:0]           rsp_samples_averaged
);
   import ppsiea_pkg::*;

   localparam int MAG_W  = SUM_W + FRACTION_BITS;
   localparam int STEP_W = $clog2(MAG_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);
   localparam logic [MAG_W-1:0]  POS_LIM   = MAG_W'(MEAN_MAX);
   localparam logic [MAG_W-1:0]  NEG_LIM   = MAG_W'(MEAN_MAX) + MAG_W'(1);

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_SAT, B_OUT} bstate_type;

   bstate_type        state_ff;
   rec_type           hold_ff;
   logic              neg_ff;
   logic [MAG_W-1:0]  quot_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic [MEAN_W-1:0] q40_ff;
   logic              out_valid_ff;

   logic [SUM_W-1:0]  mag_in;
   logic [CNT_W:0]    trial;
   logic              ge;
   logic [CNT_W:0]    diff;
   logic [MAG_W-1:0]  limit;
   logic              load_out;
   logic [MEAN_W-1:0] mean_in;

   always_comb begin
      mag_in   = q_rec.sum[SUM_W-1] ? (~q_rec.sum + SUM_W'(1)) : q_rec.sum;
      trial    = {rem_ff, quot_ff[MAG_W-1]};
      ge       = (trial >= {1'b0, hold_ff.count});
      diff     = trial - {1'b0, hold_ff.count};
      limit    = neg_ff ? NEG_LIM : POS_LIM;
      mean_in  = neg_ff ? (~q40_ff + MEAN_W'(1)) : q40_ff;
      load_out = (state_ff == B_OUT) && (!out_valid_ff || rsp_pop);
      q_pop    = (state_ff == B_IDLE) && !q_stat.empty;
      rsp_empty = !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (!q_stat.empty) begin
                  hold_ff  <= q_rec;
                  neg_ff   <= q_rec.sum[SUM_W-1];
                  quot_ff  <= MAG_W'(mag_in) << FRACTION_BITS;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               // one quotient bit a cycle, shifted in where the dividend leaves
               rem_ff  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
               quot_ff <= {quot_ff[MAG_W-2:0], ge};
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == LAST_STEP) begin
                  state_ff <= B_SAT;
               end
            end
            B_SAT: begin
               q40_ff   <= (quot_ff > limit) ? limit[MEAN_W-1:0] : quot_ff[MEAN_W-1:0];
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (load_out) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load_out) begin
         rsp_edge_number      <= hold_ff.edge_number;
         rsp_period           <= hold_ff.interval;
         rsp_period_error     <= hold_ff.error;
         rsp_mean_error_q8    <= mean_in;
         rsp_samples_averaged <= hold_ff.count;
      end
   end

endmodule

// ===== hw/rtl/ppsiea_checker.sv =====
// Port-level checker for the PPS interval error averager, bound to the top.
// Depends on pps_interval_error_averager_core_assert.svh and ppsiea_pkg.
`include "pps_interval_error_averager_core_assert.svh"

module ppsiea_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_empty,
   input logic                                   rsp_pop,
   input logic [ppsiea_pkg::TIME_W-1:0]          rsp_edge_number,
   input logic signed [ppsiea_pkg::TIME_W-1:0]   rsp_period_error,
   input logic signed [ppsiea_pkg::MEAN_W-1:0]   rsp_mean_error_q8,
   input logic [ppsiea_pkg::CNT_W-1:0]           rsp_samples_averaged
);
   import ppsiea_pkg::*;

   logic                     edge_counted;
   logic                     lone_sample;
   logic                     sign_match;
   logic                     stalled;
   logic [TIME_W+MEAN_W-1:0] shown;

   always_comb begin
      edge_counted = (rsp_edge_number != '0) && (rsp_edge_number != TIME_W'(1));
      lone_sample  = (rsp_samples_averaged == CNT_W'(1)) && (rsp_period_error != '0);
      sign_match   = (rsp_mean_error_q8[MEAN_W-1] == rsp_period_error[TIME_W-1]);
      stalled      = !rsp_empty && !rsp_pop;
      shown        = {rsp_edge_number, rsp_mean_error_q8};
   end

   // no result may stand right after reset
   `PPSIEA_ASSERT_NEXT_ALWAYS(a_empty_after_reset, clock, reset, rsp_empty, "result after reset")

   // the first edge and edges where the count wraps give no result
   `PPSIEA_ASSERT_NOW(a_edge_number, clock, reset, !rsp_empty, edge_counted, "dropped edge shown")

   // a lone sample's mean carries the sign of its error
   `PPSIEA_ASSERT_NOW(a_single_sign, clock, reset, !rsp_empty && lone_sample, sign_match, "bad sign")

   // a stalled result holds
   `PPSIEA_ASSERT_NEXT(a_hold, clock, reset, stalled, !rsp_empty && $stable(shown), "result moved")

endmodule

bind pps_interval_error_averager_core ppsiea_checker u_ppsiea_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_edge_number      (rsp_edge_number),
   .rsp_period_error     (rsp_period_error),
   .rsp_mean_error_q8    (rsp_mean_error_q8),
   .rsp_samples_averaged (rsp_samples_averaged)
);

// ===== tb/ppsiea_report_checker.sv =====
// Report checker for the PPS interval error averager: tracks the edge
// bookkeeping, predicts each report and compares every report the block pops.
// Depends on ppsiea_pkg for widths, reset values and register indexes.
module ppsiea_report_checker #(
   parameter int FRACTION_BITS = ppsiea_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [ppsiea_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic [ppsiea_pkg::TIME_W-1:0]        req_edge_time_us,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic [ppsiea_pkg::TIME_W-1:0]        rsp_edge_number,
   input  logic [ppsiea_pkg::TIME_W-1:0]        rsp_period,
   input  logic signed [ppsiea_pkg::TIME_W-1:0] rsp_period_error,
   input  logic signed [ppsiea_pkg::MEAN_W-1:0] rsp_mean_error_q8,
   input  logic [ppsiea_pkg::CNT_W-1:0]         rsp_samples_averaged,
   output int                                   mismatch_count,
   output int                                   reports_waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import ppsiea_pkg::*;

   typedef struct packed {
      logic [TIME_W-1:0] edge_number;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] error;
      logic [MEAN_W-1:0] mean;
      logic [CNT_W-1:0]  samples;
   } edge_report_type;

   logic [TIME_W-1:0] nominal_us;
   logic [CNT_W-1:0]  window_len;
   logic [TIME_W-1:0] last_stamp;
   logic [TIME_W-1:0] edge_count;
   longint            err_sum;
   int unsigned       avg_count;
   edge_report_type   reports_due[$];

   // Sum scaled by 2^FRACTION_BITS over the count, truncated toward zero, clipped to 40 bits.
   function automatic logic [MEAN_W-1:0] q8_mean(input longint sum, input int unsigned cnt);
      longint unsigned mag;
      longint unsigned divisor;
      longint unsigned quo;
      longint unsigned cap;
      mag = (sum < 0) ? -sum : sum;
      mag = mag << FRACTION_BITS;
      divisor = (cnt == 0) ? 1 : cnt;
      quo = mag / divisor;
      cap = (sum < 0) ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
      if (quo > cap)
         quo = cap;
      if (sum < 0)
         quo = -quo;
      return quo[MEAN_W-1:0];
   endfunction

   task automatic forecast_edge(input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] err_bits;
      int unsigned       cnt;
      edge_report_type   rep;
      gap = stamp - last_stamp;
      last_stamp = stamp;
      edge_count = edge_count + 1;
      // no report on the first edge, nor when the edge counter wraps to 0 or 1
      if (edge_count > 1) begin
         err_bits = gap - nominal_us;
         cnt = avg_count + 1;
         if (cnt > window_len) begin
            err_sum = longint'(signed'(err_bits));
            cnt = 1;
         end else begin
            err_sum = err_sum + longint'(signed'(err_bits));
         end
         avg_count = cnt & 8'hFF;
         rep.edge_number = edge_count;
         rep.interval    = gap;
         rep.error       = err_bits;
         rep.mean        = q8_mean(err_sum, avg_count);
         rep.samples     = avg_count[CNT_W-1:0];
         reports_due.push_back(rep);
      end
   endtask

   task automatic match_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_report();
      edge_report_type rep;
      if (reports_due.size() == 0) begin
         $error("report popped with none outstanding: edge_number %0d", rsp_edge_number);
         mismatch_count++;
      end else begin
         rep = reports_due.pop_front();
         match_field("edge_number", longint'(rep.edge_number), longint'(rsp_edge_number));
         match_field("period", longint'(rep.interval), longint'(rsp_period));
         match_field("period_error", longint'($signed(rep.error)), longint'(rsp_period_error));
         match_field("mean_error_q8", longint'($signed(rep.mean)),
                     longint'(rsp_mean_error_q8));
         match_field("samples_averaged", longint'(rep.samples),
                     longint'(rsp_samples_averaged));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         nominal_us = NOMINAL_RESET;
         window_len = WINDOW_RESET;
         last_stamp = '0;
         edge_count = '0;
         err_sum = 0;
         avg_count = 0;
         reports_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NOMINAL: nominal_us = csr_wdata[TIME_W-1:0];
               CSR_WINDOW:  window_len = csr_wdata[CNT_W-1:0];
               default:     ;
            endcase
         end
         if (req_push && !req_full)
            forecast_edge(req_edge_time_us);
         if (rsp_pop && !rsp_empty)
            check_report();
      end
      reports_waiting <= reports_due.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the PPS interval error averager: drives edges, register
// writes and pops under several idling patterns, and gives the verdict.
// Depends on ppsiea_pkg, pps_interval_error_averager_core and ppsiea_report_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppsiea_pkg::*;

   // cycles without any accepted item before the run is declared hung,
   // far beyond what a correct run needs for a report
   localparam int STALL_LIMIT   = 4000;
   // quiet cycles after the last report, covering the front and the divider
   localparam int SETTLE_CYCLES = 80;

   typedef enum logic [1:0] {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_we = 1'b0;
   logic                     csr_index = CSR_NOMINAL;
   logic [CSR_W-1:0]         csr_wdata = '0;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [TIME_W-1:0]        req_edge_time_us = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [TIME_W-1:0]        rsp_edge_number;
   logic [TIME_W-1:0]        rsp_period;
   logic signed [TIME_W-1:0] rsp_period_error;
   logic signed [MEAN_W-1:0] rsp_mean_error_q8;
   logic [CNT_W-1:0]         rsp_samples_averaged;

   int                mismatch_count;
   int                reports_waiting;
   pace_type          pace = PACE_NONE;
   logic [TIME_W-1:0] stamp = '0;
   int                idle_cycles = 0;

   pps_interval_error_averager_core uut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_edge_time_us     (req_edge_time_us),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_edge_number      (rsp_edge_number),
      .rsp_period           (rsp_period),
      .rsp_period_error     (rsp_period_error),
      .rsp_mean_error_q8    (rsp_mean_error_q8),
      .rsp_samples_averaged (rsp_samples_averaged)
   );

   ppsiea_report_checker report_check (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_edge_time_us     (req_edge_time_us),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_edge_number      (rsp_edge_number),
      .rsp_period           (rsp_period),
      .rsp_period_error     (rsp_period_error),
      .rsp_mean_error_q8    (rsp_mean_error_q8),
      .rsp_samples_averaged (rsp_samples_averaged),
      .mismatch_count       (mismatch_count),
      .reports_waiting      (reports_waiting)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Sender rests with odds of 58 in a hundred in its own phase, 8 when both sides idle.
   function automatic bit sender_rests();
      if (pace == PACE_SEND)
         return $urandom_range(99) < 58;
      if (pace == PACE_BOTH)
         return $urandom_range(99) < 8;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (pace == PACE_RECV)
         return $urandom_range(99) < 58;
      if (pace == PACE_BOTH)
         return $urandom_range(99) < 8;
      return 1'b0;
   endfunction

   // Receiver: decide pop afresh on every edge, one assignment per step.
   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= !receiver_stalls();
   end

   // Watchdog: any accepted push or pop restarts the count.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one edge and hold it until accepted. Push is left high so that a
   // following call can keep it up back to back without lowering it first.
   task automatic push_edge(input logic [TIME_W-1:0] edge_stamp);
      while (sender_rests()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_edge_time_us <= edge_stamp;
      do
         @(posedge clock);
      while (req_full);
   endtask

   // Drop push, wait for every outstanding report, then let the block settle.
   task automatic wait_idle();
      req_push <= 1'b0;
      do
         @(negedge clock);
      while (reports_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges; write enable stays high between.
   task automatic configure(input logic [TIME_W-1:0] nominal, input logic [CNT_W-1:0] window);
      csr_we <= 1'b1;
      csr_index <= CSR_NOMINAL;
      csr_wdata <= CSR_W'(nominal);
      @(posedge clock);
      csr_index <= CSR_WINDOW;
      csr_wdata <= CSR_W'(window);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-behaved pulse trains around the nominal interval, with some
   // coarse jitter, arbitrary timestamps, arbitrary intervals and repeats.
   task automatic send_edges(input logic [TIME_W-1:0] nominal, input int count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 70)
            stamp = stamp + nominal + 32'($urandom_range(200)) - 32'd100;
         else if (pick < 82)
            stamp = stamp + nominal + $urandom_range(32'h0020_0000) - 32'h0010_0000;
         else if (pick < 92)
            stamp = $urandom();
         else if (pick < 97)
            stamp = stamp + $urandom();
         // otherwise repeat the stamp: zero interval
         push_edge(stamp);
      end
   endtask

   task automatic run_phase(input logic [TIME_W-1:0] nominal, input logic [CNT_W-1:0] window,
                            input pace_type mode, input int count);
      wait_idle();
      configure(nominal, window);
      pace <= mode;
      send_edges(nominal, count);
   endtask

   initial begin
      logic [TIME_W-1:0] hops[$];
      logic [TIME_W-1:0] extremes[$];

      hops = '{32'd1000000, 32'd1000001, 32'd999998, 32'd0, 32'd999999};
      extremes = '{NOMINAL_RESET, NOMINAL_RESET + 32'h7FFF_FFFF,
                   NOMINAL_RESET + 32'h8000_0000, 32'hFFFF_FFFF, 32'd1000003, 32'd999997};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset register values: first edge with no report,
      // exact, early and late intervals, a zero interval, the top timestamp,
      // a timer wrap, and the largest positive and negative errors.
      stamp = '0;
      push_edge(stamp);
      foreach (hops[i]) begin
         stamp = stamp + hops[i];
         push_edge(stamp);
      end
      stamp = '1;
      push_edge(stamp);
      foreach (extremes[i]) begin
         stamp = stamp + extremes[i];
         push_edge(stamp);
      end

      // Random phases: register extremes, restart on every sample (window 1
      // and the zero window), a window that never restarts early, and every
      // idling pattern.
      run_phase(32'd1000000, 8'd60, PACE_NONE, 250);
      run_phase(32'd1, 8'd1, PACE_SEND, 200);
      run_phase(32'hFFFF_FFFF, 8'd255, PACE_RECV, 300);
      run_phase(32'd999950, 8'd0, PACE_BOTH, 150);
      run_phase($urandom_range(32'hFFFF_FFFF, 1), 8'($urandom_range(20, 2)), PACE_NONE, 200);
      run_phase(32'd12345, 8'd5, PACE_RECV, 200);
      run_phase(32'd1000000, 8'd255, PACE_SEND, 250);

      wait_idle();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ppsiea_pkg.sv
hw/rtl/ppsiea_front.sv
hw/rtl/ppsiea_queue.sv
hw/rtl/ppsiea_back.sv
hw/rtl/pps_interval_error_averager_core.sv
hw/rtl/ppsiea_checker.sv
tb/ppsiea_report_checker.sv
tb/tb.sv
